// File: rtl/dat_pkg.sv
// dat_pkg: shared constants and controller/datapath interface types
// for the device id address table; no dependencies
package dat_pkg;

  localparam int TABLE_DEPTH_DEF = 128;
  localparam int DEVICE_ID_W     = 64;
  localparam int SHORT_ADDR_W    = 8;

  typedef struct packed {
    logic load;
    logic search;
    logic finish_hit;
    logic finish_miss;
  } dat_cmd_t;

  typedef struct packed {
    logic hit;
    logic exhausted;
  } dat_status_t;

endpackage

// File: rtl/dat_ram.sv
// dat_ram: generic single write port, single read port ram with registered read
// no dependencies
module dat_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/dat_datapath.sv
// dat_datapath: key register, search index, fill count, key store and result registers
// depends on dat_pkg and dat_ram
module dat_datapath #(
  parameter int TABLE_DEPTH = dat_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dat_pkg::dat_cmd_t                cmd,
  output dat_pkg::dat_status_t             status,
  input  logic [dat_pkg::DEVICE_ID_W-1:0]  device_id,
  output logic [dat_pkg::SHORT_ADDR_W-1:0] short_address,
  output logic                             is_new,
  output logic                             table_full
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int SAW = dat_pkg::SHORT_ADDR_W;

  logic [dat_pkg::DEVICE_ID_W-1:0] key_r;
  logic [CW-1:0]                   rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic                            cmp_valid_r, cmp_valid_nxt;
  logic [AW-1:0]                   cmp_idx_r;
  logic [dat_pkg::DEVICE_ID_W-1:0] rdata;
  logic                            issue;
  logic                            full;
  logic                            we;
  logic [CW-1:0]                   hit_pos;
  logic [CW-1:0]                   new_pos;
  logic [SAW-1:0]                  addr_r;
  logic                            is_new_r;
  logic                            full_r;

  dat_ram #(
    .WIDTH(dat_pkg::DEVICE_ID_W),
    .DEPTH(TABLE_DEPTH)
  ) u_key_store (
    .clk  (clk),
    .we   (we),
    .waddr(count_r[AW-1:0]),
    .wdata(key_r),
    .raddr(rd_idx_r[AW-1:0]),
    .rdata(rdata)
  );

  always_comb begin
    full    = (count_r == CW'(TABLE_DEPTH));
    issue   = cmd.search && (rd_idx_r < count_r);
    we      = cmd.finish_miss && !full;
    hit_pos = CW'(cmp_idx_r) + CW'(1);
    new_pos = count_r + CW'(1);

    rd_idx_nxt    = rd_idx_r;
    cmp_valid_nxt = 1'b0;
    if (cmd.load) begin
      rd_idx_nxt = '0;
    end else if (issue) begin
      rd_idx_nxt    = rd_idx_r + CW'(1);
      cmp_valid_nxt = 1'b1;
    end

    count_nxt = we ? new_pos : count_r;

    status.hit       = cmp_valid_r && (rdata == key_r);
    status.exhausted = !cmp_valid_r && (rd_idx_r == count_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r    <= '0;
      count_r     <= '0;
      cmp_valid_r <= 1'b0;
    end else begin
      rd_idx_r    <= rd_idx_nxt;
      count_r     <= count_nxt;
      cmp_valid_r <= cmp_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= device_id;
    end
    cmp_idx_r <= rd_idx_r[AW-1:0];
    if (cmd.finish_hit) begin
      addr_r   <= SAW'(hit_pos);
      is_new_r <= 1'b0;
      full_r   <= 1'b0;
    end else if (cmd.finish_miss) begin
      addr_r   <= full ? '0 : SAW'(new_pos);
      is_new_r <= !full;
      full_r   <= full;
    end
  end

  assign short_address = addr_r;
  assign is_new        = is_new_r;
  assign table_full    = full_r;

endmodule

// File: rtl/dat_ctrl.sv
// dat_ctrl: request sequencer; accepts a request, steps the search, signals the result
// depends on dat_pkg
module dat_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  output logic                 out_strobe,
  output dat_pkg::dat_cmd_t    cmd,
  input  dat_pkg::dat_status_t status
);

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   strobe_r, strobe_nxt;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    busy_nxt   = busy_r;
    strobe_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SEARCH;
          busy_nxt  = 1'b1;
        end
      end
      ST_SEARCH: begin
        if (status.hit) begin
          cmd.finish_hit = 1'b1;
          state_nxt      = ST_IDLE;
          busy_nxt       = 1'b0;
          strobe_nxt     = 1'b1;
        end else if (status.exhausted) begin
          cmd.finish_miss = 1'b1;
          state_nxt       = ST_IDLE;
          busy_nxt        = 1'b0;
          strobe_nxt      = 1'b1;
        end else begin
          cmd.search = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        busy_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      busy_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      busy_r   <= busy_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign busy       = busy_r;
  assign out_strobe = strobe_r;

endmodule

// File: rtl/device_id_address_table_top.sv
// device_id_address_table_top: short address allocator for device ids
// depends on dat_pkg, dat_ctrl, dat_datapath
//
//   channel   ports                                             handshake
//   request   in_device_id                                      start && !busy
//   result    out_short_address, out_is_new, out_table_full     out_strobe, one cycle
//
// a miss reads every filled entry from the key store before the result strobe, a hit
// stops once the matching entry has been read, and a miss on an empty table reads none;
// the key store is read one entry per cycle during a search.
// the result is held on the ports until the next one; a request may be accepted with the strobe.
// synchronous active-low reset empties the table; key store contents need no clearing.
// the result side cannot stall; busy holds off requests during a search.
module device_id_address_table_top #(
  parameter int TABLE_DEPTH = dat_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [dat_pkg::DEVICE_ID_W-1:0]  in_device_id,
  output logic                             out_strobe,
  output logic [dat_pkg::SHORT_ADDR_W-1:0] out_short_address,
  output logic                             out_is_new,
  output logic                             out_table_full
);

  dat_pkg::dat_cmd_t    cmd;
  dat_pkg::dat_status_t status;

  dat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_strobe(out_strobe),
    .cmd       (cmd),
    .status    (status)
  );

  dat_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .device_id    (in_device_id),
    .short_address(out_short_address),
    .is_new       (out_is_new),
    .table_full   (out_table_full)
  );

endmodule

// File: rtl/dat_chk.sv
// dat_chk: port-level checks for device_id_address_table_top, attached by bind
// depends on dat_pkg
module dat_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             out_strobe,
  input logic [dat_pkg::SHORT_ADDR_W-1:0] out_short_address,
  input logic                             out_is_new,
  input logic                             out_table_full
);

  // accepted request keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accepted request");

  // search ends exactly with a result
  a_end_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("busy dropped without a result");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe longer than one cycle");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_is_new && out_table_full))
    else $error("new entry and full both flagged");

  a_full_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_table_full |-> out_short_address == '0)
    else $error("full result carries a nonzero address");

endmodule

bind device_id_address_table_top dat_chk u_dat_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_strobe       (out_strobe),
  .out_short_address(out_short_address),
  .out_is_new       (out_is_new),
  .out_table_full   (out_table_full)
);
